/* design/rqdp_pkg.sv */
// ----------------------------------------------------------------------------
// rqdp_pkg
// Shared types and constants for the request queue with drop policy.
// ----------------------------------------------------------------------------
package rqdp_pkg;

   localparam int DEFAULT_DEPTH = 64;

   localparam logic [2:0] ACT_ENQUEUE     = 3'd0;
   localparam logic [2:0] ACT_REMOVE_HEAD = 3'd1;
   localparam logic [2:0] ACT_REMOVE_TAIL = 3'd2;
   localparam logic [2:0] ACT_REMOVE_VAL  = 3'd3;
   localparam logic [2:0] ACT_REMOVE_POS  = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   localparam logic [1:0] ADDR_MAX_ENTRIES = 2'd0;

   localparam logic [6:0] MAX_ENTRIES_RESET = 7'd64;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] item_value;
      logic [31:0]        arrival_sec;
      logic [19:0]        arrival_usec;
      logic [5:0]         position;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] removed_value;
      logic signed [31:0] head_value;
      logic [31:0]        head_sec;
      logic [19:0]        head_usec;
      logic [6:0]         entry_count;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_SEARCH_RD, S_SEARCH_CMP, S_FETCH, S_TAKE,
      S_SHIFT_RD, S_SHIFT_WR, S_HEAD, S_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load;       // capture request
      logic       set_scan;   // set scan index to removal or search start
      logic       scan_inc;   // advance scan index
      logic       mem_rd;     // read entry at scan index
      logic       shift_rd;   // read entry at scan index + 1 for compaction
      logic       shift_wr;   // write read entry back at scan index
      logic       head_rd;    // read entry 0
      logic       enq_wr;     // write new entry at tail
      logic       count_inc;
      logic       count_dec;
      logic       rem_take;   // capture removed value from read data
      logic       st_load;    // load status code
      logic [1:0] st_code;
      logic       rsp_load;   // publish result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       empty;
      logic       full;
      logic       pos_ok;
      logic       match;     // read data value equals search value
      logic       scan_last; // scan index is last valid entry
      logic [2:0] action;
   } sts_type;

endpackage

/* design/rqdp_ctrl.sv */
// ----------------------------------------------------------------------------
// rqdp_ctrl
// Sequencer: search, compaction and head refresh steps for one word.
// ----------------------------------------------------------------------------
module rqdp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  rqdp_pkg::sts_type  sts,
   output rqdp_pkg::cmd_type  cmd
);
   rqdp_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == rqdp_pkg::S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rqdp_pkg::S_IDLE: begin
            if (req_valid && req_ready) state_in = rqdp_pkg::S_DECODE;
         end
         rqdp_pkg::S_DECODE: begin
            // decode captured word
            case (sts.action)
               rqdp_pkg::ACT_ENQUEUE: state_in = rqdp_pkg::S_HEAD;
               rqdp_pkg::ACT_REMOVE_HEAD, rqdp_pkg::ACT_REMOVE_TAIL: begin
                  state_in = sts.empty ? rqdp_pkg::S_HEAD : rqdp_pkg::S_FETCH;
               end
               rqdp_pkg::ACT_REMOVE_POS: begin
                  state_in = (sts.empty || !sts.pos_ok) ? rqdp_pkg::S_HEAD :
                             rqdp_pkg::S_FETCH;
               end
               rqdp_pkg::ACT_REMOVE_VAL: begin
                  state_in = sts.empty ? rqdp_pkg::S_HEAD : rqdp_pkg::S_SEARCH_RD;
               end
               default: state_in = rqdp_pkg::S_HEAD;
            endcase
         end
         rqdp_pkg::S_SEARCH_RD: state_in = rqdp_pkg::S_SEARCH_CMP;
         rqdp_pkg::S_SEARCH_CMP: begin
            if (sts.match) state_in = rqdp_pkg::S_SHIFT_RD;
            else if (sts.scan_last) state_in = rqdp_pkg::S_HEAD;
            else state_in = rqdp_pkg::S_SEARCH_RD;
         end
         rqdp_pkg::S_FETCH: state_in = rqdp_pkg::S_TAKE;
         rqdp_pkg::S_TAKE:  state_in = rqdp_pkg::S_SHIFT_RD;
         rqdp_pkg::S_SHIFT_RD: begin
            state_in = sts.scan_last ? rqdp_pkg::S_HEAD : rqdp_pkg::S_SHIFT_WR;
         end
         rqdp_pkg::S_SHIFT_WR: state_in = rqdp_pkg::S_SHIFT_RD;
         rqdp_pkg::S_HEAD:     state_in = rqdp_pkg::S_DONE;
         rqdp_pkg::S_DONE:     state_in = rqdp_pkg::S_IDLE;
         default:              state_in = rqdp_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         rqdp_pkg::S_IDLE: cmd.load = req_valid && req_ready;
         rqdp_pkg::S_DECODE: begin
            case (sts.action)
               rqdp_pkg::ACT_ENQUEUE: begin
                  cmd.st_load = 1'b1;
                  if (sts.full) begin
                     cmd.st_code = rqdp_pkg::ST_FULL;
                  end else begin
                     cmd.st_code   = rqdp_pkg::ST_OK;
                     cmd.enq_wr    = 1'b1;
                     cmd.count_inc = 1'b1;
                  end
               end
               rqdp_pkg::ACT_REMOVE_HEAD, rqdp_pkg::ACT_REMOVE_TAIL: begin
                  cmd.st_load = 1'b1;
                  if (sts.empty) begin
                     cmd.st_code = rqdp_pkg::ST_EMPTY;
                  end else begin
                     cmd.st_code  = rqdp_pkg::ST_OK;
                     cmd.set_scan = 1'b1;
                  end
               end
               rqdp_pkg::ACT_REMOVE_POS: begin
                  cmd.st_load = 1'b1;
                  if (sts.empty) begin
                     cmd.st_code = rqdp_pkg::ST_EMPTY;
                  end else if (!sts.pos_ok) begin
                     cmd.st_code = rqdp_pkg::ST_NOTFOUND;
                  end else begin
                     cmd.st_code  = rqdp_pkg::ST_OK;
                     cmd.set_scan = 1'b1;
                  end
               end
               rqdp_pkg::ACT_REMOVE_VAL: begin
                  if (sts.empty) begin
                     cmd.st_load = 1'b1;
                     cmd.st_code = rqdp_pkg::ST_EMPTY;
                  end else begin
                     cmd.set_scan = 1'b1;
                  end
               end
               default: begin
                  cmd.st_load = 1'b1;
                  cmd.st_code = rqdp_pkg::ST_NOTFOUND;
               end
            endcase
         end
         // read one entry, compare it the next cycle
         rqdp_pkg::S_SEARCH_RD: cmd.mem_rd = 1'b1;
         rqdp_pkg::S_SEARCH_CMP: begin
            if (sts.match) begin
               cmd.rem_take = 1'b1;
               cmd.st_load  = 1'b1;
               cmd.st_code  = rqdp_pkg::ST_OK;
            end else if (sts.scan_last) begin
               cmd.st_load = 1'b1;
               cmd.st_code = rqdp_pkg::ST_NOTFOUND;
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         rqdp_pkg::S_FETCH: cmd.mem_rd = 1'b1;
         rqdp_pkg::S_TAKE:  cmd.rem_take = 1'b1;
         // close the gap one entry at a time
         rqdp_pkg::S_SHIFT_RD: begin
            if (sts.scan_last) cmd.count_dec = 1'b1;
            else cmd.shift_rd = 1'b1;
         end
         rqdp_pkg::S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            cmd.scan_inc = 1'b1;
         end
         rqdp_pkg::S_HEAD: cmd.head_rd = 1'b1;
         rqdp_pkg::S_DONE: begin
            cmd.rsp_load = 1'b1;
            rsp_valid_in = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rqdp_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

/* design/rqdp_dpath.sv */
// ----------------------------------------------------------------------------
// rqdp_dpath
// Entry memory, occupancy, scan index and result registers.
// ----------------------------------------------------------------------------
module rqdp_dpath #(
   parameter int QUEUE_DEPTH = rqdp_pkg::DEFAULT_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  rqdp_pkg::req_type req_word,
   input  logic [6:0]        max_entries,
   input  rqdp_pkg::cmd_type cmd,
   output rqdp_pkg::sts_type sts,
   output rqdp_pkg::rsp_type rsp_word
);
   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int LW = (CW > 7) ? CW : 7;
   localparam int PW = (CW > 6) ? CW : 6;
   localparam int EW = 84;
   localparam logic [CW-1:0] CNT_ONE = CW'(1);

   logic [EW-1:0]      mem [QUEUE_DEPTH];
   logic [EW-1:0]      rd_ff;
   rqdp_pkg::req_type  req_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      scan_ff, scan_in;
   logic [1:0]         status_ff;
   logic signed [31:0] removed_ff;
   rqdp_pkg::rsp_type  rsp_ff;
   logic [AW-1:0]      rd_addr;
   logic               rd_en;
   logic [AW-1:0]      wr_addr;
   logic [EW-1:0]      wr_data;
   logic               wr_en;

   always_comb begin
      sts.empty     = (count_ff == '0);
      // full when count+1 exceeds min(max_entries, depth)
      sts.full      = (LW'(count_ff) >= LW'(max_entries)) ||
                      (count_ff >= CW'(QUEUE_DEPTH));
      sts.pos_ok    = (PW'(req_ff.position) < PW'(count_ff));
      sts.match     = (rd_ff[EW-1 -: 32] == req_ff.item_value);
      sts.scan_last = ((scan_ff + CNT_ONE) >= count_ff);
      sts.action    = req_ff.action;
   end

   // removal point for head, tail and position; search starts at the head
   always_comb begin
      scan_in = scan_ff;
      if (cmd.set_scan) begin
         case (req_ff.action)
            rqdp_pkg::ACT_REMOVE_TAIL: scan_in = count_ff - CNT_ONE;
            rqdp_pkg::ACT_REMOVE_POS:  scan_in = CW'(req_ff.position);
            default:                   scan_in = '0;
         endcase
      end else if (cmd.scan_inc) begin
         scan_in = scan_ff + CNT_ONE;
      end
   end

   // select read and write addresses
   always_comb begin
      rd_en   = cmd.mem_rd || cmd.shift_rd || cmd.head_rd;
      rd_addr = AW'(scan_ff);
      if (cmd.head_rd) rd_addr = '0;
      else if (cmd.shift_rd) rd_addr = AW'(scan_ff + CNT_ONE);
      wr_en   = cmd.enq_wr || cmd.shift_wr;
      wr_addr = cmd.enq_wr ? AW'(count_ff) : AW'(scan_ff);
      wr_data = cmd.enq_wr ? {req_ff.item_value, req_ff.arrival_sec, req_ff.arrival_usec} :
                rd_ff;
   end

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_word;
   end

   // occupancy and scan index
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         scan_ff  <= '0;
      end else begin
         scan_ff <= scan_in;
         if (cmd.count_inc) count_ff <= count_ff + CNT_ONE;
         else if (cmd.count_dec) count_ff <= count_ff - CNT_ONE;
      end
   end

   // status and removed value
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff  <= rqdp_pkg::ST_OK;
         removed_ff <= '0;
      end else begin
         if (cmd.st_load) status_ff <= cmd.st_code;
         if (cmd.load) removed_ff <= '0;
         else if (cmd.rem_take) removed_ff <= $signed(rd_ff[EW-1 -: 32]);
      end
   end

   // result word; head fields read zero when empty
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff <= '0;
      end else if (cmd.rsp_load) begin
         rsp_ff.status        <= status_ff;
         rsp_ff.removed_value <= removed_ff;
         rsp_ff.head_value    <= sts.empty ? '0 : $signed(rd_ff[EW-1 -: 32]);
         rsp_ff.head_sec      <= sts.empty ? '0 : rd_ff[51:20];
         rsp_ff.head_usec     <= sts.empty ? '0 : rd_ff[19:0];
         rsp_ff.entry_count   <= 7'(count_ff);
      end
   end

   assign rsp_word = rsp_ff;
endmodule

/* design/request_queue_with_drop_policy.sv */
// ----------------------------------------------------------------------------
// request_queue_with_drop_policy
// Bounded ordered queue with head, tail, value and position removal.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// req_     in         req_valid/req_ready    rqdp_pkg::req_type
// rsp_     out        rsp_valid/rsp_ready    rqdp_pkg::rsp_type
// csr_     in         APB, pready always 1   max_entries at address 0
//
// Enqueue, unknown actions and removals that fail at decode go straight to
// the head read; remove head, tail or position fetches the entry and moves
// each later entry up one place; remove by value scans from the head and, on
// a hit, moves the later entries up. The result is offered after the work and
// the next word is taken only after the result leaves. Reset clears occupancy,
// scan index, limit, control, status, removed value and result word only.
// A word waits in the output register while rsp_ready is low; req_ready holds low.
// ----------------------------------------------------------------------------
module request_queue_with_drop_policy #(
   parameter int QUEUE_DEPTH = rqdp_pkg::DEFAULT_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rqdp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rqdp_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [1:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   rqdp_pkg::cmd_type cmd;
   rqdp_pkg::sts_type sts;
   logic [6:0]        max_ff;

   // register write
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) max_ff <= rqdp_pkg::MAX_ENTRIES_RESET;
      else if (csr_psel && csr_penable && csr_pwrite &&
               csr_paddr == rqdp_pkg::ADDR_MAX_ENTRIES)
         max_ff <= csr_pwdata[6:0];
   end
   assign csr_prdata = (csr_paddr == rqdp_pkg::ADDR_MAX_ENTRIES) ? {25'd0, max_ff} : 32'd0;

   rqdp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .sts, .cmd
   );

   rqdp_dpath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dpath (
      .clock, .reset, .req_word(req_data), .max_entries(max_ff), .cmd, .sts,
      .rsp_word(rsp_data)
   );
endmodule

/* tb/sv/request_queue_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// request_queue_checker
// Watches the request and response channels of the request queue, keeps a
// shadow queue to predict each response word and compares field by field.
// ----------------------------------------------------------------------------
module request_queue_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  rqdp_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  rqdp_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [1:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output int                fail_count,
   output int                pending_count
);
   localparam int DEPTH = rqdp_pkg::DEFAULT_DEPTH;

   logic [31:0]       shadow_val[$];
   logic [31:0]       shadow_sec[$];
   logic [19:0]       shadow_usec[$];
   logic [6:0]        limit_reg;
   rqdp_pkg::rsp_type expected_words[$];

   // compute the response word for one accepted request and update the shadow
   function automatic rqdp_pkg::rsp_type apply_request(rqdp_pkg::req_type rq);
      rqdp_pkg::rsp_type r;
      int                hit;
      int                lim;
      r = '0;
      r.status = rqdp_pkg::ST_NOTFOUND;
      lim = (limit_reg < DEPTH) ? limit_reg : DEPTH;
      hit = -1;
      if (rq.action == rqdp_pkg::ACT_ENQUEUE) begin
         if (shadow_val.size() + 1 > lim) begin
            r.status = rqdp_pkg::ST_FULL;
         end else begin
            shadow_val.push_back(rq.item_value);
            shadow_sec.push_back(rq.arrival_sec);
            shadow_usec.push_back(rq.arrival_usec);
            r.status = rqdp_pkg::ST_OK;
         end
      end else if (rq.action <= rqdp_pkg::ACT_REMOVE_POS) begin
         if (shadow_val.size() == 0) begin
            r.status = rqdp_pkg::ST_EMPTY;
         end else begin
            case (rq.action)
               rqdp_pkg::ACT_REMOVE_HEAD: hit = 0;
               rqdp_pkg::ACT_REMOVE_TAIL: hit = shadow_val.size() - 1;
               rqdp_pkg::ACT_REMOVE_VAL: begin
                  foreach (shadow_val[i])
                     if (hit < 0 && shadow_val[i] == rq.item_value) hit = i;
               end
               default: if (rq.position < shadow_val.size()) hit = rq.position;
            endcase
            if (hit >= 0) begin
               r.removed_value = shadow_val[hit];
               shadow_val.delete(hit);
               shadow_sec.delete(hit);
               shadow_usec.delete(hit);
               r.status = rqdp_pkg::ST_OK;
            end
         end
      end
      if (shadow_val.size() > 0) begin
         r.head_value = shadow_val[0];
         r.head_sec   = shadow_sec[0];
         r.head_usec  = shadow_usec[0];
      end
      r.entry_count = 7'(shadow_val.size());
      return r;
   endfunction

   always @(posedge clock) begin
      rqdp_pkg::rsp_type e;
      if (reset) begin
         shadow_val.delete();
         shadow_sec.delete();
         shadow_usec.delete();
         expected_words.delete();
         limit_reg <= rqdp_pkg::MAX_ENTRIES_RESET;
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         // track the limit register
         if (csr_psel && csr_penable && csr_pwrite &&
             csr_paddr == rqdp_pkg::ADDR_MAX_ENTRIES)
            limit_reg <= csr_pwdata[6:0];
         if (req_valid && req_ready)
            expected_words.push_back(apply_request(req_data));
         // compare the oldest expected word
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected response word %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_words.pop_front();
               if (rsp_data !== e) begin
                  fail_count <= fail_count + 1;
                  if (rsp_data.status !== e.status)
                     $error("status exp %0d got %0d", e.status, rsp_data.status);
                  if (rsp_data.removed_value !== e.removed_value)
                     $error("removed_value exp %0d got %0d", e.removed_value,
                            rsp_data.removed_value);
                  if (rsp_data.head_value !== e.head_value)
                     $error("head_value exp %0d got %0d", e.head_value,
                            rsp_data.head_value);
                  if (rsp_data.head_sec !== e.head_sec)
                     $error("head_sec exp %0d got %0d", e.head_sec, rsp_data.head_sec);
                  if (rsp_data.head_usec !== e.head_usec)
                     $error("head_usec exp %0d got %0d", e.head_usec, rsp_data.head_usec);
                  if (rsp_data.entry_count !== e.entry_count)
                     $error("entry_count exp %0d got %0d", e.entry_count,
                            rsp_data.entry_count);
               end
            end
         end
         pending_count <= expected_words.size();
      end
   end
endmodule

/* tb/sv/request_queue_with_drop_policy_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// request_queue_with_drop_policy_test
// Drives directed and random queue operations with bursty requests, a
// stalling receiver and several queue limits; the checker does the scoring.
// ----------------------------------------------------------------------------
module request_queue_with_drop_policy_test;

   localparam int STALL_LIMIT = 20000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   rqdp_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rqdp_pkg::rsp_type rsp_data;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [1:0]        csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;
   int                fail_count;
   int                pending_count;
   int                idle_cycles;
   int                live_values[$];

   request_queue_with_drop_policy dut (.*);

   request_queue_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver stall pattern: random ready, mostly high with occasional stalls
   initial begin
      int mode;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         mode = $urandom_range(0, 99);
         if (mode < 10) rsp_ready <= 1'b0;
         else if (mode < 70) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 2) != 0);
      end
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic write_limit(input logic [6:0] limit);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= rqdp_pkg::ADDR_MAX_ENTRIES;
      csr_pwdata  <= {25'd0, limit};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // hold one request word until accepted, then lower valid for a gap unless keep_valid is set
   task automatic send_request(input rqdp_pkg::req_type rq, input bit keep_valid);
      req_data  <= rq;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (rq.action == rqdp_pkg::ACT_ENQUEUE) live_values.push_back(rq.item_value);
      if (!keep_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (140) @(posedge clock);
   endtask

   function automatic rqdp_pkg::req_type make_request(input logic [2:0] act, input int v,
                                                      input logic [5:0] pos);
      rqdp_pkg::req_type rq;
      rq.action       = act;
      rq.item_value   = v;
      rq.arrival_sec  = $urandom;
      rq.arrival_usec = 20'($urandom_range(0, 1) ? $urandom_range(0, 999999) : $urandom);
      rq.position     = pos;
      return rq;
   endfunction

   // random word: mostly valid operations against the live contents
   function automatic rqdp_pkg::req_type random_request();
      int roll;
      int v;
      roll = $urandom_range(0, 99);
      v = $urandom;
      if (roll < 45)
         return make_request(rqdp_pkg::ACT_ENQUEUE,
                             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : v,
                             6'($urandom));
      if (roll < 55) return make_request(rqdp_pkg::ACT_REMOVE_HEAD, v, 6'($urandom));
      if (roll < 65) return make_request(rqdp_pkg::ACT_REMOVE_TAIL, v, 6'($urandom));
      if (roll < 80) begin
         if (live_values.size() > 0 && $urandom_range(0, 3) != 0)
            v = live_values[$urandom_range(0, live_values.size() - 1)];
         return make_request(rqdp_pkg::ACT_REMOVE_VAL, v, 6'($urandom));
      end
      if (roll < 97)
         return make_request(rqdp_pkg::ACT_REMOVE_POS, v,
                             6'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom));
      return make_request(3'($urandom_range(5, 7)), v, 6'($urandom));
   endfunction

   initial begin
      rqdp_pkg::req_type rq;
      int                burst;
      logic [6:0]        limits[6];
      limits = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd5, 7'd33};
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = 2'd0;
      csr_pwdata  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty removals, extremes, fill to full, every action
      send_request(make_request(rqdp_pkg::ACT_REMOVE_HEAD, 0, 6'd0), 1'b0);
      send_request(make_request(rqdp_pkg::ACT_REMOVE_TAIL, 0, 6'd0), 1'b0);
      send_request(make_request(rqdp_pkg::ACT_REMOVE_VAL, 0, 6'd0), 1'b0);
      send_request(make_request(rqdp_pkg::ACT_REMOVE_POS, 0, 6'd0), 1'b0);
      rq = make_request(rqdp_pkg::ACT_ENQUEUE, 32'h7fffffff, 6'd0);
      rq.arrival_sec = 32'hffffffff; rq.arrival_usec = 20'hfffff;
      send_request(rq, 1'b0);
      rq = make_request(rqdp_pkg::ACT_ENQUEUE, 32'h80000000, 6'd0);
      rq.arrival_sec = 32'd0; rq.arrival_usec = 20'd0;
      send_request(rq, 1'b0);
      send_request(make_request(rqdp_pkg::ACT_ENQUEUE, -1, 6'd0), 1'b1);
      send_request(make_request(rqdp_pkg::ACT_ENQUEUE, 5, 6'd0), 1'b1);
      send_request(make_request(rqdp_pkg::ACT_ENQUEUE, 5, 6'd0), 1'b0);
      send_request(make_request(rqdp_pkg::ACT_REMOVE_VAL, 5, 6'd0), 1'b0);
      send_request(make_request(rqdp_pkg::ACT_REMOVE_VAL, 12345, 6'd0), 1'b0);
      send_request(make_request(rqdp_pkg::ACT_REMOVE_POS, 0, 6'd63), 1'b0);
      send_request(make_request(rqdp_pkg::ACT_REMOVE_POS, 0, 6'd1), 1'b0);
      send_request(make_request(rqdp_pkg::ACT_REMOVE_TAIL, 0, 6'd0), 1'b0);
      send_request(make_request(3'd7, 0, 6'd0), 1'b0);
      send_request(make_request(3'd5, 0, 6'd0), 1'b0);
      send_request(make_request(rqdp_pkg::ACT_REMOVE_HEAD, 0, 6'd0), 1'b0);
      wait_drained();
      write_limit(7'd2);
      send_request(make_request(rqdp_pkg::ACT_ENQUEUE, 1, 6'd0), 1'b1);
      send_request(make_request(rqdp_pkg::ACT_ENQUEUE, 2, 6'd0), 1'b1);
      send_request(make_request(rqdp_pkg::ACT_ENQUEUE, 3, 6'd0), 1'b0);
      wait_drained();

      // random phases across several limits, bursts with gaps
      foreach (limits[p]) begin
         write_limit(limits[p]);
         for (int n = 0; n < 280; n += burst) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++) begin
               rq = random_request();
               send_request(rq, k != burst - 1);
               if (rq.action == rqdp_pkg::ACT_REMOVE_VAL ||
                   rq.action == rqdp_pkg::ACT_REMOVE_HEAD)
                  foreach (live_values[i])
                     if (live_values[i] == rq.item_value) begin
                        live_values.delete(i);
                        break;
                     end
            end
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(0, 20)) @(posedge clock);
            if ($urandom_range(0, 40) == 0) while (pending_count != 0) @(posedge clock);
         end
         wait_drained();
      end

      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

/* sim.f */
design/rqdp_pkg.sv
design/rqdp_ctrl.sv
design/rqdp_dpath.sv
design/request_queue_with_drop_policy.sv
tb/sv/request_queue_checker.sv
tb/sv/request_queue_with_drop_policy_test.sv
